@@ rtl/scpd_pkg.sv @@
// Package for the sum-checked packet deframer: beat types, result codes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scpd_pkg;

	// Buffer depth default and frame layout
	localparam int unsigned MAX_ARGS_DEF = 32;
	localparam int unsigned TICKET_BYTES = 4;
	localparam int unsigned LEN_OVERHEAD = 2;

	// Input beat codes
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_ARG    = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_TIMEOUT  = 2'd1;
	localparam logic [1:0] STAT_BAD_LEN  = 2'd2;
	localparam logic [1:0] STAT_BAD_SUM  = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [31:0] ticket;
		logic [7:0]  command;
		logic [5:0]  arg_count;
		logic [4:0]  arg_index;
		logic [7:0]  arg_byte;
		logic        last;
	} out_item_t;

	// Which result the output register loads
	typedef enum logic [2:0] {
		SEL_ARG     = 3'd0,
		SEL_ACCEPT  = 3'd1,
		SEL_REJ_TMO = 3'd2,
		SEL_REJ_LEN = 3'd3,
		SEL_REJ_SUM = 3'd4
	} out_sel_t;

	// Controller -> datapath
	typedef struct packed {
		logic     tkt_first;
		logic     tkt_shift;
		logic     len_load;
		logic     cmd_load;
		logic     arg_write;
		logic     rd_clear;
		logic     rd_next;
		logic     out_load;
		out_sel_t out_sel;
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic start_hit;
		logic tkt_done;
		logic len_bad;
		logic args_zero;
		logic args_last;
		logic sum_ok;
		logic rd_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/scpd_dpath.sv @@
// Deframer datapath: start byte register, ticket/length/command/sum registers,
// argument buffer memory and the output register. Depends on scpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scpd_dpath #(
	parameter int unsigned MAX_ARGS = scpd_pkg::MAX_ARGS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic [7:0]        rx_byte,
	input  wire scpd_pkg::dp_cmd_t cmd,
	output scpd_pkg::dp_sts_t      sts,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output scpd_pkg::out_item_t    out_data
);
	import scpd_pkg::*;

	localparam int unsigned AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	logic [7:0]  start_q;
	logic [31:0] ticket_q;
	logic [7:0]  command_q;
	logic [7:0]  sum_q;
	logic [5:0]  cnt_q;
	logic [5:0]  total_q;
	logic [5:0]  rd_idx_q;
	logic [7:0]  rd_data_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [7:0]  mem [MAX_ARGS];

	logic [8:0]  len_m2;
	logic [6:0]  cnt_inc;
	logic [6:0]  rd_inc;
	out_item_t   out_next;

	assign len_m2  = {1'b0, rx_byte} - 9'(LEN_OVERHEAD);
	assign cnt_inc = {1'b0, cnt_q} + 7'd1;
	assign rd_inc  = {1'b0, rd_idx_q} + 7'd1;

	// Status toward the controller
	always_comb begin
		sts.start_hit = (rx_byte == start_q);
		sts.tkt_done  = (cnt_q >= 6'(TICKET_BYTES - 1));
		sts.len_bad   = (rx_byte < 8'(LEN_OVERHEAD)) || (len_m2 > 9'(MAX_ARGS));
		sts.args_zero = (total_q == 6'd0);
		sts.args_last = (cnt_inc >= {1'b0, total_q});
		sts.sum_ok    = (rx_byte == sum_q);
		sts.rd_last   = (rd_inc >= {1'b0, total_q});
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Start byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'hFF;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
		end
	end

	// Frame header, counters and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticket_q  <= '0;
			command_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			total_q   <= '0;
			rd_idx_q  <= '0;
		end else begin
			if (cmd.tkt_first) begin
				ticket_q <= {24'd0, rx_byte};
				sum_q    <= rx_byte;
				cnt_q    <= 6'd1;
			end
			if (cmd.tkt_shift) begin
				ticket_q <= {ticket_q[23:0], rx_byte};
				sum_q    <= sum_q + rx_byte;
				cnt_q    <= cnt_inc[5:0];
			end
			if (cmd.len_load) begin
				total_q <= len_m2[5:0];
				sum_q   <= sum_q + rx_byte;
			end
			if (cmd.cmd_load) begin
				command_q <= rx_byte;
				sum_q     <= sum_q + rx_byte;
				cnt_q     <= '0;
			end
			if (cmd.arg_write) begin
				sum_q <= sum_q + rx_byte;
				cnt_q <= cnt_inc[5:0];
			end
			if (cmd.rd_clear) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_inc[5:0];
			end
		end
	end

	// Argument buffer: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.arg_write) begin
			mem[cnt_q[AW-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q[AW-1:0]];
	end

	// Result selection
	always_comb begin
		out_next = '0;
		unique case (cmd.out_sel)
			SEL_ARG: begin
				out_next.kind      = KIND_ARG;
				out_next.status    = STAT_OK;
				out_next.ticket    = ticket_q;
				out_next.command   = command_q;
				out_next.arg_count = total_q;
				out_next.arg_index = rd_idx_q[4:0];
				out_next.arg_byte  = rd_data_q;
				out_next.last      = 1'b0;
			end
			SEL_ACCEPT: begin
				out_next.kind      = KIND_ACCEPT;
				out_next.status    = STAT_OK;
				out_next.ticket    = ticket_q;
				out_next.command   = command_q;
				out_next.arg_count = total_q;
				out_next.last      = 1'b1;
			end
			SEL_REJ_TMO: begin
				out_next.kind   = KIND_REJECT;
				out_next.status = STAT_TIMEOUT;
				out_next.last   = 1'b1;
			end
			SEL_REJ_LEN: begin
				out_next.kind   = KIND_REJECT;
				out_next.status = STAT_BAD_LEN;
				out_next.ticket = ticket_q;
				out_next.last   = 1'b1;
			end
			SEL_REJ_SUM: begin
				out_next.kind      = KIND_REJECT;
				out_next.status    = STAT_BAD_SUM;
				out_next.ticket    = ticket_q;
				out_next.command   = command_q;
				out_next.arg_count = total_q;
				out_next.last      = 1'b1;
			end
			default: out_next = '0;
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ rtl/scpd_ctrl.sv @@
// Deframer controller: one-hot frame state machine that sequences the
// datapath and the result burst. Depends on scpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_cmd,
	output logic                   in_ready,
	input  wire scpd_pkg::dp_sts_t sts,
	output scpd_pkg::dp_cmd_t      cmd
);
	import scpd_pkg::*;

	typedef enum logic [8:0] {
		ST_HUNT     = 9'b000000001,
		ST_TICKET   = 9'b000000010,
		ST_LENGTH   = 9'b000000100,
		ST_COMMAND  = 9'b000001000,
		ST_ARGS     = 9'b000010000,
		ST_CHECK    = 9'b000100000,
		ST_EMIT_RD  = 9'b001000000,
		ST_EMIT_ARG = 9'b010000000,
		ST_EMIT_ACC = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   start_seen_q, start_seen_d;
	logic   rx_state;
	logic   accept;

	// Receiving states take a beat only when the output register can take a result
	assign rx_state = (state_q == ST_HUNT) || (state_q == ST_TICKET) ||
	                  (state_q == ST_LENGTH) || (state_q == ST_COMMAND) ||
	                  (state_q == ST_ARGS) || (state_q == ST_CHECK);
	assign in_ready = rx_state && sts.out_free;
	assign accept   = in_valid && in_ready;

	// Next state and datapath commands
	always_comb begin
		state_d      = state_q;
		start_seen_d = start_seen_q;
		cmd          = '0;
		cmd.out_sel  = SEL_ARG;
		if (accept && (in_cmd == CMD_TIMEOUT)) begin
			cmd.out_load = 1'b1;
			cmd.out_sel  = SEL_REJ_TMO;
			state_d      = ST_HUNT;
			start_seen_d = 1'b0;
		end else begin
			unique case (state_q)
				ST_HUNT: begin
					if (accept) begin
						if (sts.start_hit) begin
							start_seen_d = 1'b1;
						end else if (start_seen_q) begin
							cmd.tkt_first = 1'b1;
							state_d       = ST_TICKET;
						end
					end
				end
				ST_TICKET: begin
					if (accept) begin
						cmd.tkt_shift = 1'b1;
						if (sts.tkt_done) begin
							state_d = ST_LENGTH;
						end
					end
				end
				ST_LENGTH: begin
					if (accept) begin
						if (sts.len_bad) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = SEL_REJ_LEN;
							state_d      = ST_HUNT;
							start_seen_d = 1'b0;
						end else begin
							cmd.len_load = 1'b1;
							state_d      = ST_COMMAND;
						end
					end
				end
				ST_COMMAND: begin
					if (accept) begin
						cmd.cmd_load = 1'b1;
						state_d      = sts.args_zero ? ST_CHECK : ST_ARGS;
					end
				end
				ST_ARGS: begin
					if (accept) begin
						cmd.arg_write = 1'b1;
						if (sts.args_last) begin
							state_d = ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (accept) begin
						if (!sts.sum_ok) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = SEL_REJ_SUM;
							state_d      = ST_HUNT;
							start_seen_d = 1'b0;
						end else begin
							cmd.rd_clear = 1'b1;
							state_d      = sts.args_zero ? ST_EMIT_ACC : ST_EMIT_RD;
						end
					end
				end
				// Buffer read issued here, data registered for the next state
				ST_EMIT_RD: begin
					state_d = ST_EMIT_ARG;
				end
				ST_EMIT_ARG: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = SEL_ARG;
						cmd.rd_next  = 1'b1;
						state_d      = sts.rd_last ? ST_EMIT_ACC : ST_EMIT_RD;
					end
				end
				ST_EMIT_ACC: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = SEL_ACCEPT;
						state_d      = ST_HUNT;
						start_seen_d = 1'b0;
					end
				end
				default: begin
					state_d      = ST_HUNT;
					start_seen_d = 1'b0;
				end
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			start_seen_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			start_seen_q <= start_seen_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sum_checked_packet_deframer_core.sv @@
// Top level of the sum-checked packet deframer: controller plus datapath.
// Depends on scpd_pkg, scpd_ctrl and scpd_dpath.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_wdata (start byte)
//   in        in         in_valid / in_ready  in_data  (in_item_t)
//   out       out        out_valid / out_ready out_data (out_item_t)
//
// A received beat is taken while the output register is free or
// draining. A good packet then emits each argument beat by a buffer read
// and then an output load, and closes with the accepted beat; the
// input is held off during that burst. Output back-pressure stretches both.
// Reset is asynchronous; the argument buffer needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sum_checked_packet_deframer_core #(
	parameter int unsigned MAX_ARGS = scpd_pkg::MAX_ARGS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire scpd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output scpd_pkg::out_item_t      out_data
);
	import scpd_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	scpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	scpd_dpath #(
		.MAX_ARGS (MAX_ARGS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (in_data.rx_byte),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

@@ rtl/scpd_chk.sv @@
// Port-level checker for the deframer top level and its bind statement.
// Depends on scpd_pkg and sum_checked_packet_deframer_core.
`timescale 1ns / 1ps
`default_nettype none
module scpd_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire scpd_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire scpd_pkg::out_item_t out_data
);
	import scpd_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// Input is only taken when the output register has room
	a_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken with output register full");

	// Only the closing beat of a burst carries last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.kind != KIND_ARG)))
		else $error("last flag does not match kind");

	// Rejects carry a failure status, others carry ok
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.kind == KIND_REJECT) == (out_data.status != STAT_OK)))
		else $error("status does not match kind");

	// A timeout beat yields a timeout reject right after
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.cmd == CMD_TIMEOUT) |=>
		out_valid && (out_data.kind == KIND_REJECT) && (out_data.status == STAT_TIMEOUT))
		else $error("timeout did not produce a reject");

endmodule

bind sum_checked_packet_deframer_core scpd_chk u_scpd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
